@@ rtl/core/i2cee_pkg.sv @@
package i2cee_pkg;

   // Default widths and reset values.
   localparam int unsigned COUNT_BITS_DEFAULT = 8;
   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h50;

   // Function codes of an input item.
   typedef enum logic [1:0] {
      FUNC_START_READ  = 2'd0,
      FUNC_START_WRITE = 2'd1,
      FUNC_EVENT       = 2'd2,
      FUNC_UNUSED      = 2'd3
   } func_type;

   // Sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE        = 4'd0,
      PH_WRITE_NEXT  = 4'd1,
      PH_WRITE_FINAL = 4'd2,
      PH_SEND_ACK    = 4'd3,
      PH_WAIT_ACK    = 4'd4,
      PH_READ_ONE    = 4'd5,
      PH_READ_FIRST  = 4'd6,
      PH_READ_NEXT   = 4'd7,
      PH_READ_FINAL  = 4'd8,
      PH_READ_WAIT   = 4'd9
   } phase_type;

   // Commands for the I2C master core.
   typedef enum logic [3:0] {
      CMD_NONE         = 4'd0,
      CMD_SINGLE_SEND  = 4'd1,
      CMD_BSEND_START  = 4'd2,
      CMD_BSEND_CONT   = 4'd3,
      CMD_BSEND_FINISH = 4'd4,
      CMD_SINGLE_RECV  = 4'd5,
      CMD_BRECV_START  = 4'd6,
      CMD_BRECV_CONT   = 4'd7,
      CMD_BRECV_FINISH = 4'd8
   } cmd_type;

   // Input transaction.
   typedef struct packed {
      logic [1:0]  func;
      logic [10:0] mem_address;
      logic [7:0]  byte_count;
      logic [7:0]  tx_byte;
      logic [7:0]  rx_byte;
      logic        bus_error;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic [3:0] master_cmd;
      logic       slave_address_valid;
      logic [6:0] slave_address;
      logic       receive_mode;
      logic       put_valid;
      logic [7:0] put_data;
      logic       store_valid;
      logic [7:0] store_data;
      logic       idle;
   } rsp_type;

endpackage

@@ rtl/core/i2cee_step.sv @@
module i2cee_step #(
   parameter int unsigned COUNT_BITS = i2cee_pkg::COUNT_BITS_DEFAULT
) (
   input  i2cee_pkg::phase_type  phase,
   input  logic [COUNT_BITS-1:0] count,
   input  logic [6:0]            device_address,
   input  i2cee_pkg::req_type    req,
   output i2cee_pkg::phase_type  phase_in,
   output logic [COUNT_BITS-1:0] count_in,
   output i2cee_pkg::rsp_type    rsp
);

   logic [COUNT_BITS-1:0] start_count;
   logic [COUNT_BITS-1:0] count_dec;
   logic                  is_start;
   logic                  is_event;

   assign start_count = COUNT_BITS'(req.byte_count);
   assign count_dec   = count - COUNT_BITS'(1);
   assign is_start    = (req.func inside {i2cee_pkg::FUNC_START_READ,
                                          i2cee_pkg::FUNC_START_WRITE});
   assign is_event    = (req.func == i2cee_pkg::FUNC_EVENT);

   // Next phase and remaining byte count.
   always_comb begin
      phase_in = phase;
      count_in = count;
      if (is_start && phase == i2cee_pkg::PH_IDLE) begin
         count_in = start_count;
         if (req.func == i2cee_pkg::FUNC_START_READ) begin
            phase_in = (start_count == COUNT_BITS'(1)) ? i2cee_pkg::PH_READ_ONE
                                                       : i2cee_pkg::PH_READ_FIRST;
         end else begin
            phase_in = (start_count == COUNT_BITS'(1)) ? i2cee_pkg::PH_WRITE_FINAL
                                                       : i2cee_pkg::PH_WRITE_NEXT;
         end
      end else if (is_event) begin
         case (phase)
            i2cee_pkg::PH_WRITE_NEXT: begin
               count_in = count_dec;
               if (count_dec == COUNT_BITS'(1)) phase_in = i2cee_pkg::PH_WRITE_FINAL;
            end
            i2cee_pkg::PH_WRITE_FINAL: begin
               count_in = count_dec;
               phase_in = i2cee_pkg::PH_SEND_ACK;
            end
            i2cee_pkg::PH_SEND_ACK: begin
               phase_in = i2cee_pkg::PH_WAIT_ACK;
            end
            i2cee_pkg::PH_WAIT_ACK: begin
               phase_in = req.bus_error ? i2cee_pkg::PH_WAIT_ACK : i2cee_pkg::PH_IDLE;
            end
            i2cee_pkg::PH_READ_ONE: begin
               phase_in = i2cee_pkg::PH_READ_WAIT;
            end
            i2cee_pkg::PH_READ_FIRST: begin
               phase_in = (count == COUNT_BITS'(2)) ? i2cee_pkg::PH_READ_FINAL
                                                    : i2cee_pkg::PH_READ_NEXT;
            end
            i2cee_pkg::PH_READ_NEXT: begin
               count_in = count_dec;
               if (count_dec == COUNT_BITS'(2)) phase_in = i2cee_pkg::PH_READ_FINAL;
            end
            i2cee_pkg::PH_READ_FINAL: begin
               count_in = count_dec;
               phase_in = i2cee_pkg::PH_READ_WAIT;
            end
            i2cee_pkg::PH_READ_WAIT: begin
               count_in = count_dec;
               phase_in = i2cee_pkg::PH_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   // Command and data fields of the result.
   always_comb begin
      rsp = '0;
      if (is_start && phase == i2cee_pkg::PH_IDLE) begin
         rsp.slave_address_valid = 1'b1;
         rsp.slave_address       = device_address | {4'b0000, req.mem_address[10:8]};
         rsp.put_valid           = 1'b1;
         rsp.put_data            = req.mem_address[7:0];
         rsp.master_cmd          = (req.func == i2cee_pkg::FUNC_START_READ)
                                   ? i2cee_pkg::CMD_SINGLE_SEND
                                   : i2cee_pkg::CMD_BSEND_START;
      end else if (is_event) begin
         case (phase)
            i2cee_pkg::PH_WRITE_NEXT: begin
               rsp.put_valid  = 1'b1;
               rsp.put_data   = req.tx_byte;
               rsp.master_cmd = i2cee_pkg::CMD_BSEND_CONT;
            end
            i2cee_pkg::PH_WRITE_FINAL: begin
               rsp.put_valid  = 1'b1;
               rsp.put_data   = req.tx_byte;
               rsp.master_cmd = i2cee_pkg::CMD_BSEND_FINISH;
            end
            i2cee_pkg::PH_SEND_ACK, i2cee_pkg::PH_READ_ONE: begin
               rsp.slave_address_valid = 1'b1;
               rsp.slave_address       = device_address;
               rsp.receive_mode        = 1'b1;
               rsp.master_cmd          = i2cee_pkg::CMD_SINGLE_RECV;
            end
            i2cee_pkg::PH_WAIT_ACK: begin
               // Keep polling with single receives while the device is busy.
               if (req.bus_error) begin
                  rsp.slave_address_valid = 1'b1;
                  rsp.slave_address       = device_address;
                  rsp.receive_mode        = 1'b1;
                  rsp.master_cmd          = i2cee_pkg::CMD_SINGLE_RECV;
               end
            end
            i2cee_pkg::PH_READ_FIRST: begin
               rsp.slave_address_valid = 1'b1;
               rsp.slave_address       = device_address;
               rsp.receive_mode        = 1'b1;
               rsp.master_cmd          = i2cee_pkg::CMD_BRECV_START;
            end
            i2cee_pkg::PH_READ_NEXT: begin
               rsp.store_valid = 1'b1;
               rsp.store_data  = req.rx_byte;
               rsp.master_cmd  = i2cee_pkg::CMD_BRECV_CONT;
            end
            i2cee_pkg::PH_READ_FINAL: begin
               rsp.store_valid = 1'b1;
               rsp.store_data  = req.rx_byte;
               rsp.master_cmd  = i2cee_pkg::CMD_BRECV_FINISH;
            end
            i2cee_pkg::PH_READ_WAIT: begin
               rsp.store_valid = 1'b1;
               rsp.store_data  = req.rx_byte;
            end
            default: begin
            end
         endcase
      end
      rsp.idle = (phase_in == i2cee_pkg::PH_IDLE);
   end

endmodule

@@ rtl/core/i2c_eeprom_transfer_sequencer.sv @@
// I2C EEPROM transfer sequencer.
// Request channel (req_valid/req_ready/req_payload): a start read or start
// write transaction taken while idle latches the byte count and issues the
// address phase; each master completion event then steps the sequencer.
// Response channel (rsp_valid/rsp_ready/rsp_payload): exactly one response
// per request, carrying the master command, slave address, data to put into
// the master, a received byte to store, and whether the sequencer is idle.
// csr_write_enable/csr_write_data set the 7-bit device base address; write it
// only while no transactions are in flight.
// The request waits in the input register, then the phase logic loads the
// output register, whose valid flag drives rsp_valid.
// Throughput is one transaction per cycle while the output is not stalled;
// the phase and count registers update in one step, so nothing iterates.
// When the receiver stalls, the output register holds its response and the
// input register holds one more request; req_ready then drops.
// Synchronous reset empties both registers, returns the sequencer to idle
// with a zero count, and sets the base address to 0x50.
module i2c_eeprom_transfer_sequencer #(
   parameter int unsigned COUNT_BITS = i2cee_pkg::COUNT_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  i2cee_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output i2cee_pkg::rsp_type rsp_payload,
   input  logic               csr_write_enable,
   input  logic [6:0]         csr_write_data
);

   logic                  req_valid_ff;
   i2cee_pkg::req_type    req_ff;
   logic                  rsp_valid_ff;
   i2cee_pkg::rsp_type    rsp_ff;
   i2cee_pkg::phase_type  phase_ff;
   i2cee_pkg::phase_type  phase_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic [6:0]            device_address_ff;
   i2cee_pkg::rsp_type    rsp_in;
   logic                  out_free;
   logic                  advance;

   // Pipeline flow control.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = req_valid_ff && out_free;
   assign req_ready = !req_valid_ff || advance;

   i2cee_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .phase          (phase_ff),
      .count          (count_ff),
      .device_address (device_address_ff),
      .req            (req_ff),
      .phase_in       (phase_in),
      .count_in       (count_in),
      .rsp            (rsp_in)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff      <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         phase_ff          <= i2cee_pkg::PH_IDLE;
         count_ff          <= '0;
         device_address_ff <= i2cee_pkg::DEVICE_ADDRESS_RESET;
      end else begin
         if (req_ready) req_valid_ff <= req_valid;
         if (out_free) rsp_valid_ff <= req_valid_ff;
         if (advance) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
         if (csr_write_enable) device_address_ff <= csr_write_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) req_ff <= req_payload;
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

@@ dv/tb_i2c_eeprom_transfer_sequencer.sv @@
module tb_i2c_eeprom_transfer_sequencer;
   timeunit 1ns;
   timeprecision 1ps;

   import i2cee_pkg::*;

   localparam int unsigned ITEMS_TARGET = 1750;
   localparam int unsigned CONFIG_PHASES = 5;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PRINT_LIMIT = 40;

   // Predicts the sequencer and holds the responses still owed by the block.
   class transfer_scoreboard;
      logic [6:0] base_address;
      phase_type  phase;
      logic [7:0] bytes_left;
      rsp_type    pending_responses[$];
      int unsigned mismatches;
      int unsigned requests;
      int unsigned responses;
      logic [8:0] commands_seen;

      function new();
         base_address = DEVICE_ADDRESS_RESET;
         phase = PH_IDLE;
         bytes_left = '0;
         mismatches = 0;
         requests = 0;
         responses = 0;
         commands_seen = '0;
      endfunction

      // Steps the sequencer for one accepted transaction and queues its response.
      function void note_request(req_type r);
         rsp_type want;
         logic    poll;
         want = '0;
         poll = 1'b0;
         case (func_type'(r.func))
            FUNC_START_READ, FUNC_START_WRITE: begin
               if (phase == PH_IDLE) begin
                  bytes_left = r.byte_count;
                  want.slave_address_valid = 1'b1;
                  want.slave_address = base_address | {4'b0000, r.mem_address[10:8]};
                  want.put_valid = 1'b1;
                  want.put_data = r.mem_address[7:0];
                  if (func_type'(r.func) == FUNC_START_READ) begin
                     phase = (bytes_left == 8'd1) ? PH_READ_ONE : PH_READ_FIRST;
                     want.master_cmd = CMD_SINGLE_SEND;
                  end else begin
                     phase = (bytes_left == 8'd1) ? PH_WRITE_FINAL : PH_WRITE_NEXT;
                     want.master_cmd = CMD_BSEND_START;
                  end
               end
            end
            FUNC_EVENT: begin
               case (phase)
                  PH_WRITE_NEXT: begin
                     want.put_valid = 1'b1;
                     want.put_data = r.tx_byte;
                     bytes_left = bytes_left - 8'd1;
                     want.master_cmd = CMD_BSEND_CONT;
                     if (bytes_left == 8'd1) phase = PH_WRITE_FINAL;
                  end
                  PH_WRITE_FINAL: begin
                     want.put_valid = 1'b1;
                     want.put_data = r.tx_byte;
                     bytes_left = bytes_left - 8'd1;
                     want.master_cmd = CMD_BSEND_FINISH;
                     phase = PH_SEND_ACK;
                  end
                  PH_WAIT_ACK: begin
                     if (r.bus_error == 1'b0) phase = PH_IDLE;
                     else poll = 1'b1;
                  end
                  PH_SEND_ACK: begin
                     poll = 1'b1;
                  end
                  PH_READ_ONE: begin
                     want.slave_address_valid = 1'b1;
                     want.slave_address = base_address;
                     want.receive_mode = 1'b1;
                     want.master_cmd = CMD_SINGLE_RECV;
                     phase = PH_READ_WAIT;
                  end
                  PH_READ_FIRST: begin
                     want.slave_address_valid = 1'b1;
                     want.slave_address = base_address;
                     want.receive_mode = 1'b1;
                     want.master_cmd = CMD_BRECV_START;
                     phase = (bytes_left == 8'd2) ? PH_READ_FINAL : PH_READ_NEXT;
                  end
                  PH_READ_NEXT: begin
                     want.store_valid = 1'b1;
                     want.store_data = r.rx_byte;
                     bytes_left = bytes_left - 8'd1;
                     want.master_cmd = CMD_BRECV_CONT;
                     if (bytes_left == 8'd2) phase = PH_READ_FINAL;
                  end
                  PH_READ_FINAL: begin
                     want.store_valid = 1'b1;
                     want.store_data = r.rx_byte;
                     bytes_left = bytes_left - 8'd1;
                     want.master_cmd = CMD_BRECV_FINISH;
                     phase = PH_READ_WAIT;
                  end
                  PH_READ_WAIT: begin
                     want.store_valid = 1'b1;
                     want.store_data = r.rx_byte;
                     bytes_left = bytes_left - 8'd1;
                     phase = PH_IDLE;
                  end
                  default: begin
                  end
               endcase
               // Write completion is polled with a single receive to the base address.
               if (poll) begin
                  want.slave_address_valid = 1'b1;
                  want.slave_address = base_address;
                  want.receive_mode = 1'b1;
                  want.master_cmd = CMD_SINGLE_RECV;
                  phase = PH_WAIT_ACK;
               end
            end
            default: begin
            end
         endcase
         want.idle = (phase == PH_IDLE);
         pending_responses.push_back(want);
         requests++;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("response %0d %s got 0x%0h, expected 0x%0h",
                                      responses, name, got, want));
      endtask

      // Compares one accepted response with the oldest outstanding one.
      task check_response(rsp_type got);
         rsp_type want;
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("response 0x%0h arrived with nothing outstanding", got));
            return;
         end
         want = pending_responses.pop_front();
         compare_field("master_cmd", got.master_cmd, want.master_cmd);
         compare_field("slave_address_valid", got.slave_address_valid,
                       want.slave_address_valid);
         compare_field("slave_address", got.slave_address, want.slave_address);
         compare_field("receive_mode", got.receive_mode, want.receive_mode);
         compare_field("put_valid", got.put_valid, want.put_valid);
         compare_field("put_data", got.put_data, want.put_data);
         compare_field("store_valid", got.store_valid, want.store_valid);
         compare_field("store_data", got.store_data, want.store_data);
         compare_field("idle", got.idle, want.idle);
         if (want.master_cmd <= CMD_BRECV_FINISH) commands_seen[want.master_cmd] = 1'b1;
         responses++;
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_payload;
   logic       csr_write_enable;
   logic [6:0] csr_write_data;

   transfer_scoreboard book = new();
   bit          no_stalls = 1'b0;
   int unsigned active_items = 0;
   int unsigned cycles = 0;

   i2c_eeprom_transfer_sequencer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // Clock with an 8 ns period.
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("tb_i2c_eeprom_transfer_sequencer: FAIL");
         $finish;
      end
   end

   // Response side stalls at random, except during the stall-free stretch.
   always @(negedge clock) begin
      rsp_ready <= no_stalls ? 1'b1 : ($urandom_range(99) >= 7);
   end

   // Every accepted response goes to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_response(rsp_payload);
   end

   function automatic req_type make_req(func_type f, logic [10:0] a, logic [7:0] c,
                                        logic [7:0] t, logic [7:0] rx, logic e);
      req_type r;
      r.func = f;
      r.mem_address = a;
      r.byte_count = c;
      r.tx_byte = t;
      r.rx_byte = rx;
      r.bus_error = e;
      return r;
   endfunction

   // Presents one transaction, with random gaps, and holds it until accepted.
   task automatic send_item(req_type r);
      bit ignored;
      while (!no_stalls && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = r;
      do @(posedge clock); while (!req_ready);
      ignored = (r.func == FUNC_UNUSED) ||
                (r.func == FUNC_EVENT && book.phase == PH_IDLE) ||
                (r.func != FUNC_EVENT && book.phase != PH_IDLE);
      if (!ignored) active_items++;
      book.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_event(logic err);
      send_item(make_req(FUNC_EVENT, 11'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), err));
   endtask

   // Occasionally slips in a start or an unused code while a transfer is running.
   task automatic maybe_noise();
      func_type f;
      if ($urandom_range(99) < 4) begin
         case ($urandom_range(2))
            0: f = FUNC_START_READ;
            1: f = FUNC_START_WRITE;
            default: f = FUNC_UNUSED;
         endcase
         send_item(make_req(f, 11'($urandom), 8'($urandom), 8'($urandom),
                            8'($urandom), 1'($urandom)));
      end
   endtask

   // Burst write: start, data bytes, first poll, busy polls, then the final poll.
   task automatic run_write(logic [10:0] addr, logic [7:0] count, int unsigned busy_polls);
      int unsigned n;
      n = (count == 0) ? 256 : count;
      send_item(make_req(FUNC_START_WRITE, addr, count, 8'($urandom), 8'($urandom),
                         1'($urandom)));
      repeat (n + 1) begin
         maybe_noise();
         send_event(1'($urandom));
      end
      repeat (busy_polls) begin
         maybe_noise();
         send_event(1'b1);
      end
      send_event(1'b0);
   endtask

   // Read: start, then one event per byte plus the receive command.
   task automatic run_read(logic [10:0] addr, logic [7:0] count);
      int unsigned n;
      n = (count == 0) ? 256 : count;
      send_item(make_req(FUNC_START_READ, addr, count, 8'($urandom), 8'($urandom),
                         1'($urandom)));
      repeat (n + 1) begin
         maybe_noise();
         send_event(1'($urandom));
      end
   endtask

   // Steps the sequencer with events until it is idle again.
   task automatic drain_sequencer();
      while (book.phase != PH_IDLE) send_event($urandom_range(99) < 30);
   endtask

   // Mostly short transfers, now and then a long one.
   function automatic logic [7:0] pick_count();
      int unsigned pick;
      pick = $urandom_range(199);
      if (pick == 0) return 8'd0;
      if (pick == 1) return 8'd255;
      if (pick < 5) return 8'($urandom);
      return 8'($urandom_range(6, 1));
   endfunction

   task automatic wait_for_responses();
      req_valid = 1'b0;
      while (book.pending_responses.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_base_address(logic [6:0] value);
      wait_for_responses();
      csr_write_enable = 1'b1;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      book.base_address = value;
   endtask

   task automatic run_random(int unsigned goal);
      int unsigned pick;
      while (active_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            run_write(11'($urandom), pick_count(), $urandom_range(3));
         end else if (pick < 80) begin
            run_read(11'($urandom), pick_count());
         end else if (pick < 90) begin
            // Broken transfer: a start and a few stray events, then resync.
            send_item(make_req(func_type'($urandom_range(1)), 11'($urandom),
                               8'($urandom_range(8)), 8'($urandom), 8'($urandom),
                               1'($urandom)));
            repeat ($urandom_range(3)) send_event(1'($urandom));
            drain_sequencer();
         end else begin
            // Noise: arbitrary codes; counts stay small when a start could take effect.
            repeat ($urandom_range(4, 1)) begin
               send_item(make_req(func_type'($urandom_range(3)), 11'($urandom),
                                  (book.phase == PH_IDLE) ? 8'($urandom_range(4))
                                                          : 8'($urandom),
                                  8'($urandom), 8'($urandom), 1'($urandom)));
            end
            drain_sequencer();
         end
      end
   endtask

   initial begin
      logic [6:0] base_values[CONFIG_PHASES];
      base_values = '{DEVICE_ADDRESS_RESET, 7'h7F, 7'h00, 7'($urandom), 7'h2A};
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: idle event, unused code, one-byte write with a busy start, short reads.
      send_item(make_req(FUNC_EVENT, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_item(make_req(FUNC_UNUSED, 11'h7FF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      send_item(make_req(FUNC_START_WRITE, 11'h7FF, 8'd1, 8'h00, 8'h00, 1'b0));
      send_item(make_req(FUNC_START_READ, 11'h000, 8'd2, 8'h00, 8'h00, 1'b0));
      send_item(make_req(FUNC_EVENT, 11'h000, 8'h00, 8'hFF, 8'h00, 1'b0));
      send_item(make_req(FUNC_UNUSED, 11'h000, 8'h00, 8'h00, 8'h00, 1'b0));
      send_item(make_req(FUNC_EVENT, 11'h000, 8'h00, 8'h00, 8'h00, 1'b0));
      send_item(make_req(FUNC_EVENT, 11'h000, 8'h00, 8'h00, 8'h00, 1'b1));
      send_item(make_req(FUNC_EVENT, 11'h000, 8'h00, 8'h00, 8'h00, 1'b0));
      run_read(11'h000, 8'd1);
      run_read(11'h2AA, 8'd2);
      run_read(11'h555, 8'd3);
      run_write(11'h100, 8'd2, 0);

      // Random transfers under several base addresses; one phase runs without stalls.
      for (int p = 0; p < CONFIG_PHASES; p++) begin
         if (p > 0) write_base_address(base_values[p]);
         no_stalls = (p == 2);
         run_random(ITEMS_TARGET * (p + 1) / CONFIG_PHASES);
      end
      no_stalls = 1'b0;

      wait_for_responses();
      repeat (10) @(negedge clock);
      $display("Ran %0d transactions (%0d that changed state), checked %0d responses.",
               book.requests, active_items, book.responses);
      $display("Saw %0d of 9 master commands across %0d base address settings.",
               $countones(book.commands_seen), CONFIG_PHASES);
      if (book.mismatches == 0 && book.pending_responses.size() == 0) begin
         $display("tb_i2c_eeprom_transfer_sequencer: PASS");
      end else begin
         $display("%0d mismatches, %0d responses missing", book.mismatches,
                  book.pending_responses.size());
         $display("tb_i2c_eeprom_transfer_sequencer: FAIL");
      end
      $finish;
   end

endmodule
